// File: rtl/afc_pkg.sv
// Package for the autoranging frequency counter: field widths, reset values of the
// configuration registers, register indexes, result kinds and shared types.
// Used by every module of the block; depends on nothing.
package afc_pkg;

    localparam int EDGE_COUNT_BITS_DEF = 16;
    localparam int TICK_BITS_DEF       = 32;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CLOCK_HZ_BITS  = 27;
    localparam int GATE_BITS      = 32;
    localparam int HZ_BITS        = 27;
    localparam int TIMEOUT_BITS   = 16;
    localparam int OFFSET_BITS    = 8;
    localparam int RANGE_BITS     = 3;

    localparam int EDGES_OUT_BITS = 16;
    localparam int TICKS_OUT_BITS = 32;
    localparam int FREQ_BITS      = 32;

    // 1000 fits in this many bits; a value times 1000 grows by at most this much.
    localparam int MILLI_BITS = 10;
    // Overflow of the tick counter's low half is counted in units of 65536 ticks.
    localparam int OVF_SHIFT  = 16;

    localparam logic [CLOCK_HZ_BITS-1:0] CLOCK_HZ_RESET          = 27'd20000000;
    localparam logic [GATE_BITS-1:0]     GATE_TICKS_RESET        = 32'd500000;
    localparam logic [HZ_BITS-1:0]       UPPER_HZ_RESET          = 27'd10000;
    localparam logic [HZ_BITS-1:0]       LOWER_HZ_RESET          = 27'd1000;
    localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_OVERFLOWS_RESET = 16'd80;
    localparam logic [OFFSET_BITS-1:0]   RESTART_OFFSET_RESET    = 8'd38;
    localparam logic [RANGE_BITS-1:0]    RANGE_MAX_RESET         = 3'd6;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CLOCK_HZ          = 3'd0,
        REG_GATE_TICKS        = 3'd1,
        REG_UPPER_HZ          = 3'd2,
        REG_LOWER_HZ          = 3'd3,
        REG_TIMEOUT_OVERFLOWS = 3'd4,
        REG_RESTART_OFFSET    = 3'd5,
        REG_RANGE_MAX         = 3'd6
    } cfg_reg_t;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_DIV,
        BK_RANGE,
        BK_EMIT
    } back_state_t;

    // Range feedback from the arithmetic back end to the sampling front end.
    typedef struct packed {
        logic                  update;
        logic [RANGE_BITS-1:0] range;
    } range_fb_t;

    // A frequency threshold in Hz scaled to millihertz, as shifts and subtracts.
    function automatic logic [HZ_BITS+MILLI_BITS-1:0] hz_to_milli(
        input logic [HZ_BITS-1:0] hz
    );
        logic [HZ_BITS+MILLI_BITS-1:0] wide;
        wide = (HZ_BITS+MILLI_BITS)'(hz);
        return (wide << 10) - (wide << 4) - (wide << 3);
    endfunction

endpackage

// File: rtl/afc_queue.sv
// Short register queue that carries work items from the sampling front end to the
// arithmetic back end. Generic in width and depth; uses afc_pkg only by import.
module afc_queue
    import afc_pkg::*;
#(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 room,
    input  logic                 pop,
    output logic                 head_valid,
    output logic [DATA_BITS-1:0] head_data
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0]  entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign room       = (count_reg != COUNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && room;
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The front end only pushes on an accepted item, and it accepts only with room.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != COUNT_BITS'(DEPTH)))
        else $error("item pushed into a full queue");

endmodule

// File: rtl/afc_front.sv
// Sampling front end: edge detection, tick and edge counters, gate and timeout
// decisions, range register. Depends on afc_pkg; feeds afc_queue.
module afc_front
    import afc_pkg::*;
#(
    parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF,
    parameter int TICK_BITS       = TICK_BITS_DEF,
    parameter int JOB_BITS        = 1 + 2 * RANGE_BITS + EDGE_COUNT_BITS + TICK_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic                    signal_level,
    input  logic [GATE_BITS-1:0]    gate_ticks,
    input  logic [TIMEOUT_BITS-1:0] timeout_overflows,
    input  logic [OFFSET_BITS-1:0]  restart_offset,
    output logic                    job_push,
    output logic [JOB_BITS-1:0]     job_data,
    input  logic                    job_room,
    input  range_fb_t               fb
);

    localparam int TW = (TICK_BITS > GATE_BITS) ? TICK_BITS : GATE_BITS;

    logic                       last_level_reg;
    logic                       last_level_next;
    logic                       armed_reg;
    logic                       armed_next;
    logic [TICK_BITS-1:0]       tick_count_reg;
    logic [TICK_BITS-1:0]       tick_count_next;
    logic [EDGE_COUNT_BITS-1:0] edge_count_reg;
    logic [EDGE_COUNT_BITS-1:0] edge_count_next;
    logic [RANGE_BITS-1:0]      range_setting_reg;
    logic [RANGE_BITS-1:0]      range_setting_next;
    logic                       pending_reg;
    logic                       pending_next;

    logic                       accept;
    logic                       falling;
    logic                       at_gate;
    logic                       timeout_hit;
    logic [TICK_BITS-1:0]       tick_inc;
    logic [EDGE_COUNT_BITS-1:0] edge_inc;
    logic                       job_kind;
    logic [RANGE_BITS-1:0]      job_after;
    logic [EDGE_COUNT_BITS-1:0] job_edges;
    logic [TICK_BITS-1:0]       job_ticks;

    // A measurement leaves the range open until the back end resolves it.
    assign sample_ready = !pending_reg && job_room;
    assign accept       = sample_valid && sample_ready;
    assign job_data     = {job_kind, range_setting_reg, job_after, job_edges, job_ticks};

    always_comb
    begin
        falling     = last_level_reg && !signal_level;
        edge_inc    = edge_count_reg + EDGE_COUNT_BITS'(falling);
        tick_inc    = tick_count_reg + 1'b1;
        at_gate     = TW'(tick_count_reg) >= TW'(gate_ticks);
        timeout_hit = (tick_inc[OVF_SHIFT-1:0] == '0)
                   && ((TW'(tick_inc) >> OVF_SHIFT) >= TW'(timeout_overflows))
                   && (range_setting_reg != '0);

        last_level_next    = last_level_reg;
        armed_next         = armed_reg;
        tick_count_next    = tick_count_reg;
        edge_count_next    = edge_count_reg;
        range_setting_next = range_setting_reg;
        pending_next       = pending_reg;
        job_push           = 1'b0;
        job_kind           = KIND_MEASURE;
        job_after          = range_setting_reg;
        job_edges          = edge_inc;
        job_ticks          = tick_count_reg;

        if (accept)
        begin
            last_level_next = signal_level;
            if (falling && !armed_reg)
            begin
                armed_next      = 1'b1;
                tick_count_next = '0;
                edge_count_next = '0;
            end
            else if (falling && at_gate)
            begin
                job_push        = 1'b1;
                pending_next    = 1'b1;
                tick_count_next = TICK_BITS'(restart_offset);
                edge_count_next = '0;
            end
            else if (timeout_hit)
            begin
                job_push           = 1'b1;
                job_kind           = KIND_TIMEOUT;
                job_ticks          = tick_inc;
                job_after          = range_setting_reg - 1'b1;
                range_setting_next = range_setting_reg - 1'b1;
                tick_count_next    = TICK_BITS'(restart_offset);
                edge_count_next    = '0;
            end
            else
            begin
                tick_count_next = tick_inc;
                edge_count_next = edge_inc;
            end
        end

        if (fb.update)
        begin
            range_setting_next = fb.range;
            pending_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg    <= 1'b0;
            armed_reg         <= 1'b0;
            tick_count_reg    <= '0;
            edge_count_reg    <= '0;
            range_setting_reg <= '0;
            pending_reg       <= 1'b0;
        end
        else
        begin
            last_level_reg    <= last_level_next;
            armed_reg         <= armed_next;
            tick_count_reg    <= tick_count_next;
            edge_count_reg    <= edge_count_next;
            range_setting_reg <= range_setting_next;
            pending_reg       <= pending_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && job_kind == KIND_TIMEOUT) |-> (range_setting_reg != '0))
        else $error("timeout lowered the range below zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        fb.update |-> pending_reg)
        else $error("range feedback without an outstanding measurement");

endmodule

// File: rtl/afc_back.sv
// Arithmetic back end: edge count times clock rate, scaling to millihertz, a
// bit-serial restoring divider, range adjustment and the result register.
// Depends on afc_pkg; takes work items from afc_queue.
module afc_back
    import afc_pkg::*;
#(
    parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF,
    parameter int TICK_BITS       = TICK_BITS_DEF,
    parameter int JOB_BITS        = 1 + 2 * RANGE_BITS + EDGE_COUNT_BITS + TICK_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  logic [JOB_BITS-1:0]        job_data,
    output logic                       job_pop,
    input  logic [CLOCK_HZ_BITS-1:0]   clock_hz,
    input  logic [HZ_BITS-1:0]         upper_hz,
    input  logic [HZ_BITS-1:0]         lower_hz,
    input  logic [RANGE_BITS-1:0]      range_max,
    output range_fb_t                  fb,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic                       result_kind,
    output logic [EDGES_OUT_BITS-1:0]  edges_counted,
    output logic [TICKS_OUT_BITS-1:0]  ticks_elapsed,
    output logic [FREQ_BITS-1:0]       freq_millihertz,
    output logic [RANGE_BITS-1:0]      range_used,
    output logic [RANGE_BITS-1:0]      range_next
);

    localparam int PW  = EDGE_COUNT_BITS + CLOCK_HZ_BITS;
    localparam int DW  = PW + MILLI_BITS;
    localparam int KW  = HZ_BITS + MILLI_BITS;
    localparam int SB  = $clog2(DW);
    localparam int TW  = (TICK_BITS > TICKS_OUT_BITS) ? TICK_BITS : TICKS_OUT_BITS;
    localparam int EW  = (EDGE_COUNT_BITS > EDGES_OUT_BITS) ? EDGE_COUNT_BITS
                                                           : EDGES_OUT_BITS;

    back_state_t                state_reg;
    back_state_t                state_next;
    logic                       kind_reg;
    logic                       kind_next;
    logic [RANGE_BITS-1:0]      used_reg;
    logic [RANGE_BITS-1:0]      used_next;
    logic [RANGE_BITS-1:0]      after_reg;
    logic [RANGE_BITS-1:0]      after_next;
    logic [EDGE_COUNT_BITS-1:0] edges_reg;
    logic [EDGE_COUNT_BITS-1:0] edges_next;
    logic [TICK_BITS-1:0]       ticks_reg;
    logic [TICK_BITS-1:0]       ticks_next;
    logic [PW-1:0]              prod_reg;
    logic [PW-1:0]              prod_next;
    logic [KW-1:0]              upper_k_reg;
    logic [KW-1:0]              upper_k_next;
    logic [KW-1:0]              lower_k_reg;
    logic [KW-1:0]              lower_k_next;
    logic [DW-1:0]              dq_reg;
    logic [DW-1:0]              dq_next;
    logic [TICK_BITS-1:0]       rem_reg;
    logic [TICK_BITS-1:0]       rem_next;
    logic [SB-1:0]              step_reg;
    logic [SB-1:0]              step_next;
    logic [FREQ_BITS-1:0]       freq_reg;
    logic [FREQ_BITS-1:0]       freq_next;

    logic                       result_valid_reg;
    logic                       result_valid_next;
    logic                       result_kind_reg;
    logic [EDGES_OUT_BITS-1:0]  edges_counted_reg;
    logic [TICKS_OUT_BITS-1:0]  ticks_elapsed_reg;
    logic [FREQ_BITS-1:0]       freq_millihertz_reg;
    logic [RANGE_BITS-1:0]      range_used_reg;
    logic [RANGE_BITS-1:0]      range_next_reg;
    logic                       load_result;

    logic [TICK_BITS:0]         rem_shift;
    logic                       rem_ge;
    logic [DW-1:0]              prod_wide;
    logic [DW-1:0]              upper_cmp;
    logic [DW-1:0]              lower_cmp;
    logic                       above;
    logic                       below;
    logic [RANGE_BITS-1:0]      adjusted;
    logic [TW-1:0]              ticks_ext;
    logic [EW-1:0]              edges_ext;

    assign result_valid    = result_valid_reg;
    assign result_kind     = result_kind_reg;
    assign edges_counted   = edges_counted_reg;
    assign ticks_elapsed   = ticks_elapsed_reg;
    assign freq_millihertz = freq_millihertz_reg;
    assign range_used      = range_used_reg;
    assign range_next      = range_next_reg;

    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[DW-1]};
        rem_ge    = rem_shift >= {1'b0, ticks_reg};
        prod_wide = DW'(prod_reg);
        upper_cmp = DW'(upper_k_reg);
        lower_cmp = DW'(lower_k_reg);
        ticks_ext = TW'(ticks_reg);
        edges_ext = EW'(edges_reg);

        if (ticks_reg == '0)
        begin
            above = 1'b1;
            below = 1'b0;
        end
        else
        begin
            above = (dq_reg > upper_cmp) || ((dq_reg == upper_cmp) && (rem_reg != '0));
            below = dq_reg < lower_cmp;
        end
        adjusted = used_reg;
        if (above && (adjusted < range_max))
        begin
            adjusted = adjusted + 1'b1;
        end
        if (below && (adjusted != '0))
        begin
            adjusted = adjusted - 1'b1;
        end

        state_next        = state_reg;
        kind_next         = kind_reg;
        used_next         = used_reg;
        after_next        = after_reg;
        edges_next        = edges_reg;
        ticks_next        = ticks_reg;
        prod_next         = prod_reg;
        upper_k_next      = upper_k_reg;
        lower_k_next      = lower_k_reg;
        dq_next           = dq_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        freq_next         = freq_reg;
        job_pop           = 1'b0;
        fb                = '0;
        load_result       = 1'b0;
        result_valid_next = result_valid_reg && !result_ready;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    ticks_next = job_data[TICK_BITS-1:0];
                    edges_next = job_data[TICK_BITS +: EDGE_COUNT_BITS];
                    after_next = job_data[TICK_BITS+EDGE_COUNT_BITS +: RANGE_BITS];
                    used_next  = job_data[TICK_BITS+EDGE_COUNT_BITS+RANGE_BITS +: RANGE_BITS];
                    kind_next  = job_data[JOB_BITS-1];
                    freq_next  = '0;
                    state_next = (job_data[JOB_BITS-1] == KIND_TIMEOUT) ? BK_EMIT : BK_MUL;
                end
            end
            BK_MUL:
            begin
                prod_next    = PW'(edges_reg) * PW'(clock_hz);
                upper_k_next = hz_to_milli(upper_hz);
                lower_k_next = hz_to_milli(lower_hz);
                state_next   = BK_SCALE;
            end
            BK_SCALE:
            begin
                dq_next    = (prod_wide << 10) - (prod_wide << 4) - (prod_wide << 3);
                rem_next   = '0;
                step_next  = '0;
                state_next = (ticks_reg == '0) ? BK_RANGE : BK_DIV;
            end
            BK_DIV:
            begin
                // One quotient bit per cycle; the dividend shifts out as it comes in.
                rem_next  = rem_ge ? TICK_BITS'(rem_shift - {1'b0, ticks_reg})
                                   : rem_shift[TICK_BITS-1:0];
                dq_next   = {dq_reg[DW-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == SB'(DW - 1))
                begin
                    state_next = BK_RANGE;
                end
            end
            BK_RANGE:
            begin
                if ((ticks_reg == '0) || ((dq_reg >> FREQ_BITS) != '0))
                begin
                    freq_next = '1;
                end
                else
                begin
                    freq_next = dq_reg[FREQ_BITS-1:0];
                end
                after_next = adjusted;
                fb.update  = 1'b1;
                fb.range   = adjusted;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_result       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        used_reg    <= used_next;
        after_reg   <= after_next;
        edges_reg   <= edges_next;
        ticks_reg   <= ticks_next;
        prod_reg    <= prod_next;
        upper_k_reg <= upper_k_next;
        lower_k_reg <= lower_k_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        freq_reg    <= freq_next;
        if (load_result)
        begin
            result_kind_reg     <= kind_reg;
            edges_counted_reg   <= edges_ext[EDGES_OUT_BITS-1:0];
            ticks_elapsed_reg   <= ((ticks_ext >> TICKS_OUT_BITS) != '0)
                                   ? '1 : ticks_ext[TICKS_OUT_BITS-1:0];
            freq_millihertz_reg <= freq_reg;
            range_used_reg      <= used_reg;
            range_next_reg      <= after_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fb.update |-> (({1'b0, fb.range} <= {1'b0, used_reg} + 1'b1)
                    && ({1'b0, fb.range} + 1'b1 >= {1'b0, used_reg})))
        else $error("range moved by more than one step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_TIMEOUT)
        |-> ((freq_millihertz == '0) && ({1'b0, range_next} + 1'b1 == {1'b0, range_used})))
        else $error("timeout result with a frequency or without a range drop");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg != BK_IDLE))
        else $error("work item taken but back end stayed idle");

endmodule

// File: rtl/autoranging_frequency_counter.sv
// Autoranging reciprocal frequency counter. The block takes one sample of the
// measured signal per item, normally one item every clock cycle. The first
// falling edge arms the counter; later falling edges are counted, and the first
// edge at which the elapsed tick count has reached gate_ticks closes the gate and
// yields a measurement item: edge count, elapsed ticks, frequency in millihertz
// (edges * clock_hz * 1000 / ticks, truncated and saturated to all ones) and the
// prescaler range before and after it is moved against upper_hz and lower_hz.
// A gate that runs through timeout_overflows overflows of 65536 ticks while the
// range is above zero yields a timeout item instead and lowers the range by one.
// After either result the tick count restarts at restart_offset. Rate: samples are
// taken every cycle except after a measurement edge, when the input holds off while
// the back end multiplies, scales, runs the bit-serial divider and moves the range,
// since the next sample may depend on the new range. The hold-off is longer when
// earlier items still occupy the back end, whose result register waits on
// result_ready. Timeout items do not hold off the input; they pass through a
// two-entry queue to the result register, and they stall the input only when that
// queue is full. Configuration registers are written through the plain write port
// and must only change while the block is idle.
// Depends on afc_pkg, afc_front, afc_queue and afc_back.
module autoranging_frequency_counter
    import afc_pkg::*;
#(
    parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF,
    parameter int TICK_BITS       = TICK_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_write_data,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic                       signal_level,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic                       result_kind,
    output logic [EDGES_OUT_BITS-1:0]  edges_counted,
    output logic [TICKS_OUT_BITS-1:0]  ticks_elapsed,
    output logic [FREQ_BITS-1:0]       freq_millihertz,
    output logic [RANGE_BITS-1:0]      range_used,
    output logic [RANGE_BITS-1:0]      range_next
);

    // A work item holds kind, range before, range after, edge count and ticks.
    localparam int JOB_BITS = 1 + 2 * RANGE_BITS + EDGE_COUNT_BITS + TICK_BITS;

    logic [CLOCK_HZ_BITS-1:0] clock_hz_reg;
    logic [GATE_BITS-1:0]     gate_ticks_reg;
    logic [HZ_BITS-1:0]       upper_hz_reg;
    logic [HZ_BITS-1:0]       lower_hz_reg;
    logic [TIMEOUT_BITS-1:0]  timeout_overflows_reg;
    logic [OFFSET_BITS-1:0]   restart_offset_reg;
    logic [RANGE_BITS-1:0]    range_max_reg;

    logic                     job_push;
    logic [JOB_BITS-1:0]      job_push_data;
    logic                     job_room;
    logic                     job_pop;
    logic                     job_valid;
    logic [JOB_BITS-1:0]      job_head_data;
    range_fb_t                range_fb;

    // Configuration registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg          <= CLOCK_HZ_RESET;
            gate_ticks_reg        <= GATE_TICKS_RESET;
            upper_hz_reg          <= UPPER_HZ_RESET;
            lower_hz_reg          <= LOWER_HZ_RESET;
            timeout_overflows_reg <= TIMEOUT_OVERFLOWS_RESET;
            restart_offset_reg    <= RESTART_OFFSET_RESET;
            range_max_reg         <= RANGE_MAX_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_CLOCK_HZ:
                begin
                    clock_hz_reg <= cfg_write_data[CLOCK_HZ_BITS-1:0];
                end
                REG_GATE_TICKS:
                begin
                    gate_ticks_reg <= cfg_write_data[GATE_BITS-1:0];
                end
                REG_UPPER_HZ:
                begin
                    upper_hz_reg <= cfg_write_data[HZ_BITS-1:0];
                end
                REG_LOWER_HZ:
                begin
                    lower_hz_reg <= cfg_write_data[HZ_BITS-1:0];
                end
                REG_TIMEOUT_OVERFLOWS:
                begin
                    timeout_overflows_reg <= cfg_write_data[TIMEOUT_BITS-1:0];
                end
                REG_RESTART_OFFSET:
                begin
                    restart_offset_reg <= cfg_write_data[OFFSET_BITS-1:0];
                end
                REG_RANGE_MAX:
                begin
                    range_max_reg <= cfg_write_data[RANGE_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Front end: counters, gate and timeout decisions, range register.
    afc_front #(
        .EDGE_COUNT_BITS (EDGE_COUNT_BITS),
        .TICK_BITS       (TICK_BITS),
        .JOB_BITS        (JOB_BITS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .signal_level      (signal_level),
        .gate_ticks        (gate_ticks_reg),
        .timeout_overflows (timeout_overflows_reg),
        .restart_offset    (restart_offset_reg),
        .job_push          (job_push),
        .job_data          (job_push_data),
        .job_room          (job_room),
        .fb                (range_fb)
    );

    // Queue between the halves so a stalled result need not stop sampling at once.
    afc_queue #(
        .DATA_BITS (JOB_BITS),
        .DEPTH     (QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (job_push_data),
        .room       (job_room),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_data  (job_head_data)
    );

    // Back end: multiply, scale, divide, move the range and hold the result.
    afc_back #(
        .EDGE_COUNT_BITS (EDGE_COUNT_BITS),
        .TICK_BITS       (TICK_BITS),
        .JOB_BITS        (JOB_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job_data        (job_head_data),
        .job_pop         (job_pop),
        .clock_hz        (clock_hz_reg),
        .upper_hz        (upper_hz_reg),
        .lower_hz        (lower_hz_reg),
        .range_max       (range_max_reg),
        .fb              (range_fb),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_kind     (result_kind),
        .edges_counted   (edges_counted),
        .ticks_elapsed   (ticks_elapsed),
        .freq_millihertz (freq_millihertz),
        .range_used      (range_used),
        .range_next      (range_next)
    );

endmodule

// File: tb/autoranging_frequency_counter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for autoranging_frequency_counter: drives signal samples and
// register writes, predicts every measurement and timeout reading, and checks them.
// Depends on afc_pkg and the RTL of the block; reads no files.
module autoranging_frequency_counter_test;

    import afc_pkg::*;

    // After a measurement edge the front end holds off while the divider settles the
    // new range. Registers are only touched once that is over.
    localparam int BUSY_CYCLES     = 100;
    localparam int END_CYCLES      = 200;
    localparam int HOLD_OFF_CYCLES = 600;
    // No handshake on either channel for this many cycles means the block is stuck.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam logic [31:0] HZ_MAX = 32'd100000000;

    // One reading as it leaves the block.
    typedef struct {
        logic                      kind;
        logic [EDGES_OUT_BITS-1:0] edges;
        logic [TICKS_OUT_BITS-1:0] ticks;
        logic [FREQ_BITS-1:0]      freq;
        logic [RANGE_BITS-1:0]     range_before;
        logic [RANGE_BITS-1:0]     range_after;
    } reading_t;

    // Stall patterns of the result side.
    typedef enum int {
        SINK_OPEN,
        SINK_HALF,
        SINK_SPARSE,
        SINK_HICCUP
    } sink_mode_t;

    // Scoreboard: a copy of the counter's registers and state, advanced once per
    // accepted sample, and the queue of readings that those samples have caused.
    class reading_scoreboard;
        logic [CLOCK_HZ_BITS-1:0]       clock_hz;
        logic [GATE_BITS-1:0]           gate_ticks;
        logic [HZ_BITS-1:0]             upper_hz;
        logic [HZ_BITS-1:0]             lower_hz;
        logic [TIMEOUT_BITS-1:0]        timeout_overflows;
        logic [OFFSET_BITS-1:0]         restart_offset;
        logic [RANGE_BITS-1:0]          range_max;

        logic                           last_level;
        logic                           armed;
        logic [TICK_BITS_DEF-1:0]       tick_count;
        logic [EDGE_COUNT_BITS_DEF-1:0] edge_count;
        logic [RANGE_BITS-1:0]          range_setting;

        reading_t readings_due[$];
        int samples;
        int measurements;
        int timeouts;
        int checked;
        int mismatches;

        function new();
            clock_hz          = CLOCK_HZ_RESET;
            gate_ticks        = GATE_TICKS_RESET;
            upper_hz          = UPPER_HZ_RESET;
            lower_hz          = LOWER_HZ_RESET;
            timeout_overflows = TIMEOUT_OVERFLOWS_RESET;
            restart_offset    = RESTART_OFFSET_RESET;
            range_max         = RANGE_MAX_RESET;
            last_level        = 1'b0;
            armed             = 1'b0;
            tick_count        = '0;
            edge_count        = '0;
            range_setting     = '0;
            samples           = 0;
            measurements      = 0;
            timeouts          = 0;
            checked           = 0;
            mismatches        = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_CLOCK_HZ:          clock_hz = value[CLOCK_HZ_BITS-1:0];
                REG_GATE_TICKS:        gate_ticks = value[GATE_BITS-1:0];
                REG_UPPER_HZ:          upper_hz = value[HZ_BITS-1:0];
                REG_LOWER_HZ:          lower_hz = value[HZ_BITS-1:0];
                REG_TIMEOUT_OVERFLOWS: timeout_overflows = value[TIMEOUT_BITS-1:0];
                REG_RESTART_OFFSET:    restart_offset = value[OFFSET_BITS-1:0];
                REG_RANGE_MAX:         range_max = value[RANGE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endfunction

        // Advances the counter by one sample and queues the reading it causes, if any.
        function void note_sample(logic level);
            reading_t r;
            logic falling;
            longint unsigned prod, whole, rem, milli, span;
            logic above, below;
            samples++;
            falling = last_level && !level;
            last_level = level;
            if (falling) begin
                if (!armed) begin
                    armed = 1'b1;
                    tick_count = '0;
                    edge_count = '0;
                    return;
                end
                edge_count = edge_count + 1'b1;
                if (tick_count >= gate_ticks) begin
                    span = 64'(tick_count);
                    prod = 64'(edge_count) * 64'(clock_hz);
                    r.kind = KIND_MEASURE;
                    r.edges = edge_count;
                    r.ticks = tick_count;
                    r.range_before = range_setting;
                    if (span == 0) begin
                        r.freq = '1;
                        above = 1'b1;
                        below = 1'b0;
                    end else begin
                        whole = prod / span;
                        rem = prod % span;
                        milli = whole * 1000 + (rem * 1000) / span;
                        if (whole > 64'hFFFF_FFFF || milli > 64'hFFFF_FFFF)
                            r.freq = '1;
                        else
                            r.freq = milli[31:0];
                        // Thresholds are compared against the exact quotient in Hz.
                        above = (whole > 64'(upper_hz)) ||
                                (whole == 64'(upper_hz) && rem != 0);
                        below = whole < 64'(lower_hz);
                    end
                    // The up step is taken first and the down step sees its outcome.
                    if (above && range_setting < range_max)
                        range_setting = range_setting + 1'b1;
                    if (below && range_setting != 0)
                        range_setting = range_setting - 1'b1;
                    r.range_after = range_setting;
                    readings_due.push_back(r);
                    measurements++;
                    tick_count = TICK_BITS_DEF'(restart_offset);
                    edge_count = '0;
                    return;
                end
            end
            tick_count = tick_count + 1'b1;
            if (tick_count[OVF_SHIFT-1:0] == '0 &&
                (tick_count >> OVF_SHIFT) >= TICK_BITS_DEF'(timeout_overflows) &&
                range_setting != 0) begin
                r.kind = KIND_TIMEOUT;
                r.edges = edge_count;
                r.ticks = tick_count;
                r.freq = '0;
                r.range_before = range_setting;
                range_setting = range_setting - 1'b1;
                r.range_after = range_setting;
                readings_due.push_back(r);
                timeouts++;
                tick_count = TICK_BITS_DEF'(restart_offset);
                edge_count = '0;
            end
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (readings_due.size() == 0) begin
                report($sformatf("reading %0d arrived with none outstanding", checked));
                checked++;
                return;
            end
            want = readings_due.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("reading %0d result_kind %0d, wanted %0d",
                                 checked, got.kind, want.kind));
            if (got.edges !== want.edges)
                report($sformatf("reading %0d edges_counted %0d, wanted %0d",
                                 checked, got.edges, want.edges));
            if (got.ticks !== want.ticks)
                report($sformatf("reading %0d ticks_elapsed %0d, wanted %0d",
                                 checked, got.ticks, want.ticks));
            if (got.freq !== want.freq)
                report($sformatf("reading %0d freq_millihertz %0d, wanted %0d",
                                 checked, got.freq, want.freq));
            if (got.range_before !== want.range_before)
                report($sformatf("reading %0d range_used %0d, wanted %0d",
                                 checked, got.range_before, want.range_before));
            if (got.range_after !== want.range_after)
                report($sformatf("reading %0d range_next %0d, wanted %0d",
                                 checked, got.range_after, want.range_after));
            checked++;
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_write_data = '0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic                       signal_level = 1'b0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic                       result_kind;
    logic [EDGES_OUT_BITS-1:0]  edges_counted;
    logic [TICKS_OUT_BITS-1:0]  ticks_elapsed;
    logic [FREQ_BITS-1:0]       freq_millihertz;
    logic [RANGE_BITS-1:0]      range_used;
    logic [RANGE_BITS-1:0]      range_next;

    reading_scoreboard sb = new();

    // Sender pacing: items go out in bursts; gap_max of zero means back to back.
    int gap_max = 0;
    int burst_left = 0;
    int settings = 0;
    // Set by the stimulus to ask the result side for one long hold-off.
    bit hold_req = 1'b0;

    autoranging_frequency_counter DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_write_data  (cfg_write_data),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .signal_level    (signal_level),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_kind     (result_kind),
        .edges_counted   (edges_counted),
        .ticks_elapsed   (ticks_elapsed),
        .freq_millihertz (freq_millihertz),
        .range_used      (range_used),
        .range_next      (range_next)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Offers one sample and returns at the edge that accepts it. Valid stays high
    // afterwards so that the next item of a burst follows without a bubble.
    task automatic send_level(input logic level);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sample_valid <= 1'b1;
        signal_level <= level;
        do @(posedge clk); while (sample_ready !== 1'b1);
        sb.note_sample(level);
        burst_left--;
    endtask

    // One period of the measured signal with random high and low run lengths.
    // Runs of one sample act as glitches when half_max is large.
    task automatic send_period(input int half_max);
        int high_run, low_run;
        high_run = $urandom_range(1, half_max);
        low_run = $urandom_range(1, half_max);
        repeat (high_run) send_level(1'b1);
        repeat (low_run) send_level(1'b0);
    endtask

    task automatic send_wave(input int count, input int half_max);
        int stop;
        stop = sb.samples + count;
        while (sb.samples < stop) send_period(half_max);
    endtask

    // Stops offering samples and waits until every reading is in and the back end
    // has finished any measurement it may still be working on.
    task automatic settle();
        sample_valid <= 1'b0;
        burst_left = 0;
        while (sb.readings_due.size() != 0) @(posedge clk);
        repeat (BUSY_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Every register is rewritten for each new setting.
    task automatic configure(input logic [31:0] hz, input logic [31:0] gate,
                             input logic [31:0] up, input logic [31:0] low,
                             input logic [31:0] overflows, input logic [31:0] offset,
                             input logic [31:0] top_range);
        settle();
        write_register(REG_CLOCK_HZ, hz);
        write_register(REG_GATE_TICKS, gate);
        write_register(REG_UPPER_HZ, up);
        write_register(REG_LOWER_HZ, low);
        write_register(REG_TIMEOUT_OVERFLOWS, overflows);
        write_register(REG_RESTART_OFFSET, offset);
        write_register(REG_RANGE_MAX, top_range);
        settings++;
    endtask

    // Result side: checks each accepted reading and stalls on its own pattern. On
    // request it holds ready low for a long stretch so the block backs up.
    initial
    begin : result_sink
        reading_t got;
        sink_mode_t mode;
        int mode_left;
        int held;
        mode = SINK_OPEN;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready === 1'b1)
            begin
                got.kind = result_kind;
                got.edges = edges_counted;
                got.ticks = ticks_elapsed;
                got.freq = freq_millihertz;
                got.range_before = range_used;
                got.range_after = range_next;
                sb.check_reading(got);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   result_ready <= 1'b1;
                    SINK_HALF:   result_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                    default:     result_ready <= ($urandom_range(0, 15) != 0);
                endcase
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid === 1'b1 && sample_ready === 1'b1) ||
                (result_valid === 1'b1 && result_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int round;
        int half_max;
        logic [31:0] hz, up, low, offset;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fastest clock, shortest gate, largest offset and zero thresholds.
        // The first falling edge only arms; every later edge closes a gate, the first
        // reading's frequency saturates and the range climbs until range_max stops it.
        gap_max = 0;
        configure(HZ_MAX, 32'd1, 32'd0, 32'd0, 32'd65535, 32'd255, 32'd7);
        send_level(1'b1);
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b0);
        repeat (8)
        begin
            send_level(1'b1);
            send_level(1'b0);
        end

        // Directed: slowest clock, no offset and both thresholds at HZ_MAX, with
        // range_max at zero below the current range. Readings are a fraction of one
        // hertz, truncated in millihertz, and the range only comes down.
        configure(32'd1, 32'd3, HZ_MAX, HZ_MAX, 32'd1, 32'd0, 32'd0);
        repeat (4)
        begin
            send_level(1'b1);
            send_level(1'b0);
        end

        // Random settings with small gates so measurements come often. Thresholds sit
        // near the expected frequency so the range moves both ways. One round asks
        // the result side for a long hold-off while samples keep coming.
        for (round = 0; round < 6; round++)
        begin
            case ($urandom_range(0, 3))
                0:       hz = 32'd1;
                1:       hz = HZ_MAX;
                default: hz = $urandom_range(1, 100000000);
            endcase
            half_max = $urandom_range(1, 12);
            up = hz / $urandom_range(1, 2 * half_max + 2);
            low = hz / $urandom_range(2, 4 * half_max + 4);
            if ($urandom_range(0, 5) == 0)
                up = 32'd0;
            if ($urandom_range(0, 5) == 0)
                low = HZ_MAX;
            offset = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 8);
            if (round == 2)
            begin
                configure(hz, 32'd1, up, low, $urandom_range(1, 65535), offset,
                          $urandom_range(0, 7));
                gap_max = 0;
                hold_req = 1'b1;
                send_wave(250, 1);
            end
            else
            begin
                configure(hz, $urandom_range(1, 60), up, low, $urandom_range(1, 65535),
                          offset, $urandom_range(0, 7));
                gap_max = (round % 2 == 1) ? $urandom_range(1, 8) : 0;
                send_wave(200, half_max);
            end
        end

        settle();
        repeat (END_CYCLES) @(posedge clk);

        $display("Covered %0d samples over %0d register settings, checking %0d readings:",
                 sb.samples, settings, sb.checked);
        $display("%0d measurements and %0d overflow timeouts, with saturation and back-pressure.",
                 sb.measurements, sb.timeouts);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
